// ===== rtl/slug_pkg.sv =====
// Shared types, byte codes and lookup functions for the URL slug transducer.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package slug_pkg;

    // Default depth of the queue between classifier and emitter (power of two)
    localparam int QUEUE_DEPTH_DEF = 4;

    // Held UTF-8 lead byte
    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_C2   = 2'd1;
    localparam logic [1:0] LEAD_C3   = 2'd2;

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS  = 8'h20;
    localparam logic [7:0] CH_LEAD_C2   = 8'hC2;
    localparam logic [7:0] CH_LEAD_C3   = 8'hC3;
    localparam logic [7:0] CH_SECTION   = 8'hA7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } slug_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       string_end;
    } slug_out_t;

    // All results caused by one input beat
    typedef struct packed {
        logic [1:0]      cnt;     // 1..3 results
        logic [2:0][7:0] bytes;   // slot 0 first
        logic            marker;  // end marker for a final beat with no results, sole result
        logic            last;    // final beat of the name
    } slug_pkt_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
    } slug_swap_t;

    function automatic logic is_dropped(logic [7:0] b);
        logic r;
        case (b) inside
            8'h2E, 8'h2C, 8'h23, 8'h22, 8'h25, 8'h3D, 8'h3F, 8'h27, 8'h28,
            8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'h2A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Two-byte UTF-8 characters and their ASCII spelling
    function automatic slug_swap_t swap_lookup(logic [1:0] lead, logic [7:0] second);
        slug_swap_t s;
        s = '{hit: 1'b0, len: 2'd0, c0: 8'h00, c1: 8'h00};
        if (lead == LEAD_C3) begin
            case (second)
                8'h9F: s = '{1'b1, 2'd2, 8'h73, 8'h73};  // ss
                8'hA6: s = '{1'b1, 2'd2, 8'h61, 8'h65};  // ae
                8'hA4: s = '{1'b1, 2'd2, 8'h61, 8'h65};  // ae
                8'hA8: s = '{1'b1, 2'd1, 8'h65, 8'h00};  // e
                8'hA9: s = '{1'b1, 2'd1, 8'h65, 8'h00};  // e
                8'hAA: s = '{1'b1, 2'd1, 8'h65, 8'h00};  // e
                8'hB6: s = '{1'b1, 2'd2, 8'h6F, 8'h65};  // oe
                8'hBC: s = '{1'b1, 2'd2, 8'h75, 8'h65};  // ue
                default: s.hit = 1'b0;
            endcase
        end else if (lead == LEAD_C2) begin
            case (second)
                8'hB2: s = '{1'b1, 2'd1, 8'h32, 8'h00};  // 2
                8'hB3: s = '{1'b1, 2'd1, 8'h33, 8'h00};  // 3
                default: s.hit = 1'b0;
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/url_slug_byte_transducer_core.sv =====
// Top level of the URL slug transducer: classifier, packet queue, emitter.
// Depends on slug_pkg, slug_front, slug_queue, slug_back.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one raw name byte per beat,
//   with in_last on the final byte of a name. Output channel m_valid/m_ready/
//   m_data carries slug bytes; each input beat gives zero to three result
//   beats, run_last marks the last of them and string_end the end of the name.
//   An empty name yields one beat with out_valid low.
// Timing:
//   The classifier takes one byte per cycle while the packet queue has room.
//   The emitter drains one result per cycle while m_ready is high, so the
//   sustained rate is one input beat per cycle as long as beats average one
//   result or fewer; multi-result beats (swapped letters, flushed leads) hold
//   the emitter for their extra results and are absorbed by the queue.
//   A first result is registered in the packet queue, then in the output register.
// Reset: aresetn (synchronous, active low) clears slug state, queue and the
//   output valid flag; s_ready is high the cycle after reset.
// Stall: m_ready low holds the output register; the queue fills and then
//   s_ready drops until the receiver takes beats again.
`default_nettype none

module url_slug_byte_transducer_core #(
    parameter int QUEUE_DEPTH = slug_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire slug_pkg::slug_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output slug_pkg::slug_out_t      m_data
);

    slug_pkg::slug_pkt_t push_pkt, head_pkt;
    logic                push, pop, full, empty;

    // front: classify and update slug state
    slug_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_pkt   (push_pkt)
    );

    // decouples front from back so each side stalls on its own
    slug_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head_pkt)
    );

    // back: serialize packets into result beats
    slug_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (empty),
        .q_head  (head_pkt),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/slug_front.sv =====
// Classifier: takes input beats, tracks slug state, builds one packet per beat that gives results or ends a name.
// Depends on slug_pkg.
`default_nettype none

module slug_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire slug_pkg::slug_in_t  s_data,
    input  wire logic                q_full,
    output logic                     q_push,
    output slug_pkg::slug_pkt_t      q_pkt
);

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] e;
    } emit_t;

    function automatic emit_t push(emit_t s, logic [7:0] c);
        emit_t r;
        r = s;
        if (r.n != 3'd4) begin
            r.e[r.n[1:0]] = c;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    logic       sp_reg, sp_next;
    logic [1:0] ld_reg, ld_next;
    logic       disc_reg, disc_next;
    logic       pd_reg, pd_next;
    logic       accept;
    emit_t      em;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [7:0]          b;
        logic                handled;
        slug_pkg::slug_swap_t sw;
        b       = s_data.in_byte;
        handled = 1'b0;
        sw      = slug_pkg::swap_lookup(ld_reg, 8'h00);
        em      = '0;
        sp_next   = sp_reg;
        ld_next   = ld_reg;
        disc_next = disc_reg;
        pd_next   = pd_reg;

        if (disc_reg) begin
            if (b == slug_pkg::CH_LF || b == slug_pkg::CH_CR) begin
                disc_next = 1'b0;
                em = push(em, b);
                pd_next = 1'b0;
            end
        end else begin
            if (b == slug_pkg::CH_BACKSLASH) b = slug_pkg::CH_SLASH;
            if (b >= slug_pkg::CH_UPPER_A && b <= slug_pkg::CH_UPPER_Z)
                b = b + slug_pkg::CH_CASE_OFS;
            if (!slug_pkg::is_dropped(b)) begin
                if (ld_next != slug_pkg::LEAD_NONE) begin
                    sw = slug_pkg::swap_lookup(ld_next, b);
                    if (sw.hit) begin
                        if (sp_next) begin
                            if (!pd_next) em = push(em, slug_pkg::CH_DASH);
                            pd_next = 1'b1;
                            sp_next = 1'b0;
                        end
                        ld_next = slug_pkg::LEAD_NONE;
                        em = push(em, sw.c0);
                        if (sw.len == 2'd2) em = push(em, sw.c1);
                        pd_next = 1'b0;
                        handled = 1'b1;
                    end else if (ld_next == slug_pkg::LEAD_C2 && b == slug_pkg::CH_SECTION) begin
                        disc_next = 1'b1;
                        sp_next   = 1'b0;
                        ld_next   = slug_pkg::LEAD_NONE;
                        handled   = 1'b1;
                    end else begin
                        if (sp_next) begin
                            if (!pd_next) em = push(em, slug_pkg::CH_DASH);
                            pd_next = 1'b1;
                            sp_next = 1'b0;
                        end
                        em = push(em, (ld_next == slug_pkg::LEAD_C2) ?
                                  slug_pkg::CH_LEAD_C2 : slug_pkg::CH_LEAD_C3);
                        pd_next = 1'b0;
                        ld_next = slug_pkg::LEAD_NONE;
                    end
                end
                if (!handled) begin
                    if (b == slug_pkg::CH_LEAD_C2) begin
                        ld_next = slug_pkg::LEAD_C2;
                    end else if (b == slug_pkg::CH_LEAD_C3) begin
                        ld_next = slug_pkg::LEAD_C3;
                    end else if (b == slug_pkg::CH_SPACE) begin
                        sp_next = 1'b1;
                    end else begin
                        if (sp_next) begin
                            if (!pd_next) em = push(em, slug_pkg::CH_DASH);
                            pd_next = 1'b1;
                            sp_next = 1'b0;
                        end
                        if (b == slug_pkg::CH_DASH || b == slug_pkg::CH_DOLLAR ||
                            b == slug_pkg::CH_AMP) begin
                            if (!pd_next) em = push(em, slug_pkg::CH_DASH);
                            pd_next = 1'b1;
                        end else if (b == slug_pkg::CH_SLASH) begin
                            em = push(em, slug_pkg::CH_DASH);
                            pd_next = 1'b0;
                        end else begin
                            em = push(em, b);
                            pd_next = 1'b0;
                        end
                    end
                end
            end
        end

        // end of name: flush held space run and lead byte
        if (s_data.in_last) begin
            if (sp_next) begin
                if (!pd_next) em = push(em, slug_pkg::CH_DASH);
            end
            if (ld_next != slug_pkg::LEAD_NONE) begin
                em = push(em, (ld_next == slug_pkg::LEAD_C2) ?
                          slug_pkg::CH_LEAD_C2 : slug_pkg::CH_LEAD_C3);
            end
            sp_next   = 1'b0;
            ld_next   = slug_pkg::LEAD_NONE;
            disc_next = 1'b0;
            pd_next   = 1'b0;
        end
    end

    always_comb begin
        q_pkt.bytes  = em.e[2:0];
        q_pkt.last   = s_data.in_last;
        q_pkt.marker = (em.n == 3'd0);
        if (em.n == 3'd0) begin
            q_pkt.cnt = 2'd1;
        end else if (em.n >= 3'd3) begin
            q_pkt.cnt = 2'd3;
        end else begin
            q_pkt.cnt = em.n[1:0];
        end
        q_push = accept && (em.n != 3'd0 || s_data.in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= 1'b0;
            ld_reg   <= slug_pkg::LEAD_NONE;
            disc_reg <= 1'b0;
            pd_reg   <= 1'b0;
        end else if (accept) begin
            sp_reg   <= sp_next;
            ld_reg   <= ld_next;
            disc_reg <= disc_next;
            pd_reg   <= pd_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slug_queue.sv =====
// Packet queue between classifier and emitter, flip-flop storage.
// Depends on slug_pkg.
`default_nettype none

module slug_queue #(
    parameter int DEPTH = slug_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire slug_pkg::slug_pkt_t push_pkt,
    input  wire logic                pop,
    output logic                     full,
    output logic                     empty,
    output slug_pkg::slug_pkt_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    slug_pkg::slug_pkt_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == DEPTH_C);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_pkt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == LAST_C) ? '0 : wr_reg + AW'(1);
            if (pop)  rd_reg <= (rd_reg == LAST_C) ? '0 : rd_reg + AW'(1);
            if (push && !pop)      cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slug_back.sv =====
// Emitter: walks the head packet one result per cycle, unless the output stalls, into the output register.
// Depends on slug_pkg.
`default_nettype none

module slug_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  wire slug_pkg::slug_pkt_t q_head,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output slug_pkg::slug_out_t      m_data
);

    logic [1:0]          idx_reg, idx_next;
    logic                vld_reg, vld_next;
    slug_pkg::slug_out_t data_reg, data_next;
    logic                load, at_end;

    assign load   = !q_empty && (!vld_reg || m_ready);
    assign at_end = (idx_reg == q_head.cnt - 2'd1);
    assign q_pop  = load && at_end;

    always_comb begin
        idx_next  = idx_reg;
        vld_next  = vld_reg && !m_ready;
        data_next = data_reg;
        if (load) begin
            vld_next            = 1'b1;
            data_next.out_byte  = q_head.marker ? 8'h00 : q_head.bytes[idx_reg];
            data_next.out_valid = !q_head.marker;
            data_next.run_last  = at_end;
            data_next.string_end = at_end && q_head.last;
            idx_next            = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire
